>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the CORDIC sine block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check that is switched off while reset is high.
`define CSQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Concurrent check that is also evaluated while reset is high.
`define CSQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define CSQ_ASSERT(label, clk, rst, prop)
`define CSQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/csq15_pkg.sv
// Package with widths, angle constants and the arctangent table of the CORDIC sine block.
package csq15_pkg;

   localparam int ITERATIONS = 16;
   localparam int STEP_W     = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

   localparam int ANGLE_W = 19;
   localparam int SINE_W  = 17;
   localparam int ANG_W   = 19;
   localparam int XY_W    = 18;
   localparam int ATAN_W  = 16;
   localparam int ATAN_COUNT = 15;

   localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(4 * 32'h0000_c90f);

   localparam logic signed [ANG_W:0] HALF_PI      = (ANG_W+1)'(32'h0000_c90f);
   localparam logic signed [ANG_W:0] PI_VAL       = (ANG_W+1)'(2 * 32'h0000_c90f);
   localparam logic signed [ANG_W:0] THREE_HALF   = (ANG_W+1)'(3 * 32'h0000_c90f);
   localparam logic signed [ANG_W:0] TWO_PI       = (ANG_W+1)'(4 * 32'h0000_c90f);

   localparam logic signed [XY_W-1:0] GAIN_INV = XY_W'(16'h4dba);

   function automatic logic [ATAN_W-1:0] atan_lookup(input logic [3:0] idx);
      logic [ATAN_W-1:0] res;
      unique case (idx)
         4'd0:    res = 16'h6487;
         4'd1:    res = 16'h3b58;
         4'd2:    res = 16'h1f5b;
         4'd3:    res = 16'h0fea;
         4'd4:    res = 16'h07fd;
         4'd5:    res = 16'h03ff;
         4'd6:    res = 16'h01ff;
         4'd7:    res = 16'h00ff;
         4'd8:    res = 16'h007f;
         4'd9:    res = 16'h003f;
         4'd10:   res = 16'h001f;
         4'd11:   res = 16'h000f;
         4'd12:   res = 16'h0007;
         4'd13:   res = 16'h0003;
         4'd14:   res = 16'h0001;
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

>>> rtl/core/cordic_sine_q15.sv
// Top level of the CORDIC sine block: one shared rotation stage stepped by a small sequencer.
// A transaction is accepted only while the sequencer is idle and then runs through it in order: the
// accepting cycle folds the angle, the prep state finds the quadrant, 16 iterations run one per
// cycle through a single shift/add/compare stage, the flush state loads the output, and the
// sequencer is idle again before it takes the next transaction.
// A result still waiting in the output register holds the sequencer in the flush state.
// Reset is synchronous, active high, and returns the sequencer to idle with no result pending.
`include "assert_macros.svh"

module cordic_sine_q15 import csq15_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ANGLE_W-1:0]       req_angle,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SINE_W-1:0] rsp_sine
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_FLUSH
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ITERATIONS - 1);

   // Sequencer and output handshake state.
   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Datapath registers. The folded angle is held until the quadrant is known.
   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic [1:0]                quad_ff, quad_in;
   logic signed [ANG_W-1:0]   tgt_ff, tgt_in;
   logic signed [ANG_W-1:0]   cur_ff, cur_in;
   logic signed [XY_W-1:0]    x_ff, x_in;
   logic signed [XY_W-1:0]    y_ff, y_in;
   logic signed [SINE_W-1:0]  sine_ff, sine_in;

   // Range reduction: the angle folds by one turn at most once, so an angle
   // above two turns still lands beyond one turn and is handled as quadrant 3.
   logic signed [ANG_W:0]     angle_ext;
   logic [1:0]                quad_calc;
   logic signed [ANG_W:0]     tgt_wide;

   // Shared rotation stage.
   logic signed [XY_W-1:0]    dx, dy;
   logic signed [ANG_W-1:0]   atan_ext;
   logic                      rot_up;
   logic                      out_free;

   assign angle_ext = $signed({1'b0, angle_ff});

   always_comb begin
      priority if (angle_ext > THREE_HALF) begin
         quad_calc = 2'd3;
      end else if (angle_ext > PI_VAL) begin
         quad_calc = 2'd2;
      end else if (angle_ext > HALF_PI) begin
         quad_calc = 2'd1;
      end else begin
         quad_calc = 2'd0;
      end
   end

   always_comb begin
      unique case (quad_calc)
         2'd3:    tgt_wide = TWO_PI - angle_ext;
         2'd2:    tgt_wide = angle_ext - PI_VAL;
         2'd1:    tgt_wide = PI_VAL - angle_ext;
         default: tgt_wide = angle_ext;
      endcase
   end

   // One micro-rotation: the step index sets the shift and picks the table entry.
   // Steps past the end of the table use an arctangent of zero.
   assign dx       = y_ff >>> step_ff;
   assign dy       = x_ff >>> step_ff;
   assign atan_ext = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_lookup(4'(step_ff))});
   assign rot_up   = (tgt_ff > cur_ff);

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      angle_in     = angle_ff;
      quad_in      = quad_ff;
      tgt_in       = tgt_ff;
      cur_in       = cur_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sine_in      = sine_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_angle > FULL_TURN) begin
                  angle_in = req_angle - FULL_TURN;
               end else begin
                  angle_in = req_angle;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            quad_in  = quad_calc;
            tgt_in   = ANG_W'(tgt_wide);
            cur_in   = '0;
            x_in     = GAIN_INV;
            y_in     = '0;
            step_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (rot_up) begin
               x_in   = x_ff - dx;
               y_in   = y_ff + dy;
               cur_in = cur_ff + atan_ext;
            end else begin
               x_in   = x_ff + dx;
               y_in   = y_ff - dy;
               cur_in = cur_ff - atan_ext;
            end
            if (step_ff == STEP_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            // Quadrants 2 and 3 lie below the axis, so the sign of Y flips.
            if (out_free) begin
               if (quad_ff[1]) begin
                  sine_in = SINE_W'(-y_ff);
               end else begin
                  sine_in = SINE_W'(y_ff);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      angle_ff <= angle_in;
      quad_ff  <= quad_in;
      tgt_ff   <= tgt_in;
      cur_ff   <= cur_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      sine_ff  <= sine_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_sine  = sine_ff;

   // An accepted transaction always moves the sequencer into range reduction.
   `CSQ_ASSERT(a_accept_to_prep, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_PREP))
   // The iteration counter advances by exactly one in each rotation cycle except at the last step.
   `CSQ_ASSERT(a_step_advance, clock, reset, (state_ff == ST_RUN && step_ff != STEP_LAST) |=> (step_ff == $past(step_ff) + 1'b1))
   // A new result appears only out of the flush state.
   `CSQ_ASSERT(a_rsp_from_flush, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FLUSH))
   // Reset leaves the block idle with no result pending.
   `CSQ_ASSERT_ALWAYS(a_reset_clean, clock, reset |=> (!rsp_valid && req_ready))

endmodule
